// ===== design/tme_pkg.sv =====
// ----------------------------------------------------------------------------
// tme_pkg
// Shared types and codes for the transform matrix engine.
// ----------------------------------------------------------------------------
package tme_pkg;

    typedef enum logic [2:0] {
        OP_IDENTITY  = 3'd0,
        OP_WRITE     = 3'd1,
        OP_RHS       = 3'd2,
        OP_TRANSPOSE = 3'd3,
        OP_NORMALIZE = 3'd4,
        OP_READ      = 3'd5
    } opcode_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NORM_FAIL = 2'd1;
    localparam logic [1:0] ST_SAT       = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ID_SWEEP,
        S_MUL_RD,
        S_MUL_MUL,
        S_MUL_ACC,
        S_MUL_WR,
        S_COPY_RD,
        S_COPY_WR,
        S_TR_RD,
        S_TR_WR,
        S_NM_LAST_RD,
        S_NM_LAST,
        S_NM_RD,
        S_NM_START,
        S_NM_WAIT,
        S_READ_DATA,
        S_DONE
    } state_t;

    typedef struct packed {
        logic acc_clear;
        logic mul_en;
        logic acc_en;
        logic div_start;
    } alu_ctrl_t;

    typedef struct packed {
        logic div_busy;
    } alu_stat_t;

endpackage

// ===== design/tme_ram.sv =====
// ----------------------------------------------------------------------------
// tme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/tme_alu.sv =====
// ----------------------------------------------------------------------------
// tme_alu
// Shared arithmetic unit: signed multiply-accumulate with rounding and
// saturation, and a radix-2 restoring divider for normalization.
// ----------------------------------------------------------------------------
module tme_alu #(
    parameter int MAX_DIM   = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tme_pkg::alu_ctrl_t  ctrl,
    input  logic signed [31:0]  op_a,
    input  logic signed [31:0]  op_b,
    output logic signed [31:0]  mac_q,
    output logic                mac_sat,
    output logic signed [31:0]  div_q,
    output logic                div_sat,
    output tme_pkg::alu_stat_t  stat
);

    localparam int ACCW = 64 + $clog2(MAX_DIM) + 1;
    localparam int NW   = 32 + FRAC_BITS;
    localparam int QW   = NW + 1;
    localparam int CW   = $clog2(QW + 1);

    localparam logic signed [ACCW-1:0] ACC_MAX  = ACCW'(64'sd2147483647);
    localparam logic signed [ACCW-1:0] ACC_MIN  = ACCW'(-64'sd2147483648);
    localparam logic signed [ACCW-1:0] ACC_HALF = ACCW'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic [QW-1:0]          Q_POSMAX = QW'(33'h0_7FFF_FFFF);
    localparam logic [QW-1:0]          Q_NEGMAX = QW'(33'h0_8000_0000);

    logic signed [63:0]   prod_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [ACCW-1:0] acc_rnd;
    logic signed [ACCW-1:0] acc_shr;

    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_next;
    logic [QW-1:0]  num_reg;
    logic [QW-1:0]  num_next;
    logic [31:0]    rem_reg;
    logic [31:0]    rem_next;
    logic [31:0]    dmag_reg;
    logic           neg_reg;

    logic [31:0]    amag;
    logic [31:0]    bmag;
    logic [32:0]    rem_sh;
    logic           ge;
    logic [QW-1:0]  q_neg;

    // multiply-accumulate path
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= 64'(op_a) * 64'(op_b);
        end
        if (ctrl.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg + ACCW'(prod_reg);
        end
    end

    always_comb
    begin
        acc_rnd = acc_reg + ACC_HALF;
        acc_shr = acc_rnd >>> FRAC_BITS;
        mac_sat = (acc_shr > ACC_MAX) || (acc_shr < ACC_MIN);
        if (acc_shr > ACC_MAX)
        begin
            mac_q = 32'sh7FFF_FFFF;
        end
        else if (acc_shr < ACC_MIN)
        begin
            mac_q = 32'sh8000_0000;
        end
        else
        begin
            mac_q = acc_shr[31:0];
        end
    end

    // divider: one quotient bit per cycle
    always_comb
    begin
        amag     = op_a[31] ? 32'(-op_a) : 32'(op_a);
        bmag     = op_b[31] ? 32'(-op_b) : 32'(op_b);
        rem_sh   = {rem_reg, num_reg[QW-1]};
        ge       = rem_sh >= {1'b0, dmag_reg};
        cnt_next = cnt_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        if (ctrl.div_start)
        begin
            cnt_next = CW'(QW);
            num_next = QW'({amag, {FRAC_BITS{1'b0}}}) + QW'(bmag >> 1);
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CW'(1);
            num_next = {num_reg[QW-2:0], ge};
            rem_next = ge ? 32'(rem_sh - {1'b0, dmag_reg}) : rem_sh[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (ctrl.div_start)
        begin
            dmag_reg <= bmag;
            neg_reg  <= op_a[31] ^ op_b[31];
        end
    end

    always_comb
    begin
        q_neg = QW'(0) - num_reg;
        if (neg_reg)
        begin
            div_sat = num_reg > Q_NEGMAX;
            div_q   = div_sat ? 32'sh8000_0000 : q_neg[31:0];
        end
        else
        begin
            div_sat = num_reg > Q_POSMAX;
            div_q   = div_sat ? 32'sh7FFF_FFFF : num_reg[31:0];
        end
    end

    assign stat.div_busy = (cnt_reg != '0);

endmodule

// ===== design/transform_matrix_engine.sv =====
// Write, rhs element and unknown commands go straight to S_DONE; read via S_READ_DATA.
// Multiply (rhs element with rhs_last): read, multiply, accumulate, write, copy back.
// Normalize divides each entry by the last one; the divider takes one bit a cycle.
// Transpose writes a transposed copy and copies it back; one transaction at a time.
// After reset the block writes identity into all MAX_DIM^2 entries, one per
// cycle, before in_ready rises; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
// transform_matrix_engine
// Square Q-format transform matrix with identity, element access, matrix
// multiply, transpose and normalize, sequenced over one shared unit.
// ----------------------------------------------------------------------------
module transform_matrix_engine #(
    parameter int MAX_DIM   = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         opcode,
    input  logic [3:0]         element_index,
    input  logic signed [31:0] element_value,
    input  logic               rhs_last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] read_value,
    output logic [1:0]         status
);

    import tme_pkg::*;

    localparam int CELLS   = MAX_DIM * MAX_DIM;
    localparam int AW      = $clog2(CELLS);
    localparam int DW      = $clog2(MAX_DIM + 1);
    localparam int IW      = $clog2(MAX_DIM);
    localparam int NNW     = $clog2(CELLS + 1);
    localparam int RST_DIM = (MAX_DIM < 4) ? MAX_DIM : 4;
    localparam logic [31:0] FX_ONE = 32'(1) << FRAC_BITS;

    state_t state_reg, state_next;

    logic [2:0]      dim_reg;
    logic [IW-1:0]   i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]   diag_pos_reg, diag_pos_next;
    logic [DW-1:0]   diag_cnt_reg, diag_cnt_next;
    logic [DW-1:0]   id_n_reg, id_n_next;
    logic            id_cmd_reg, id_cmd_next;
    logic            inside_reg, inside_next;
    logic [31:0]     last_reg, last_next;
    logic [31:0]     res_value_reg, res_value_next;
    logic [1:0]      res_status_reg, res_status_next;
    logic            out_valid_reg;
    logic [31:0]     out_value_reg;
    logic [1:0]      out_status_reg;

    logic [3:0]      dim_clamp;
    logic [DW-1:0]   n_eff;
    logic [NNW-1:0]  nn;
    logic            accept, idx_in_range, res_load;
    opcode_t         op;
    logic            i_last, j_last, k_last, cnt_last_nn, cnt_last_all, id_one;
    logic [AW-1:0]   addr_ik, addr_kj, addr_ij, addr_ji;

    logic            cur_we, rhs_we, prod_we;
    logic [AW-1:0]   cur_waddr, cur_raddr, rhs_raddr, prod_waddr, prod_raddr;
    logic [31:0]     cur_wdata, prod_wdata, cur_rdata, rhs_rdata, prod_rdata;

    alu_ctrl_t          alu_ctrl;
    alu_stat_t          alu_stat;
    logic signed [31:0] mac_q, div_q;
    logic               mac_sat, div_sat;

    // effective side length
    always_comb
    begin
        dim_clamp = {1'b0, dim_reg};
        if (dim_clamp < 4'd3)
        begin
            dim_clamp = 4'd3;
        end
        if (dim_clamp > 4'(MAX_DIM))
        begin
            dim_clamp = 4'(MAX_DIM);
        end
        n_eff = DW'(dim_clamp);
        nn    = NNW'(n_eff) * NNW'(n_eff);
    end

    assign accept       = in_valid && in_ready;
    assign op           = opcode_t'(opcode);
    assign idx_in_range = 8'(element_index) < 8'(nn);
    assign i_last       = i_reg == IW'(n_eff - DW'(1));
    assign j_last       = j_reg == IW'(n_eff - DW'(1));
    assign k_last       = k_reg == IW'(n_eff - DW'(1));
    assign cnt_last_nn  = cnt_reg == AW'(nn - NNW'(1));
    assign cnt_last_all = cnt_reg == AW'(CELLS - 1);
    assign id_one       = (cnt_reg == diag_pos_reg) && (diag_cnt_reg < id_n_reg);
    assign addr_ik      = AW'(i_reg) * AW'(n_eff) + AW'(k_reg);
    assign addr_kj      = AW'(k_reg) * AW'(n_eff) + AW'(j_reg);
    assign addr_ij      = AW'(i_reg) * AW'(n_eff) + AW'(j_reg);
    assign addr_ji      = AW'(j_reg) * AW'(n_eff) + AW'(i_reg);
    assign res_load     = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign in_ready     = (state_reg == S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_IDENTITY:  state_next = S_ID_SWEEP;
                        OP_RHS:       state_next = rhs_last ? S_MUL_RD : S_DONE;
                        OP_TRANSPOSE: state_next = S_TR_RD;
                        OP_NORMALIZE: state_next = S_NM_LAST_RD;
                        OP_READ:      state_next = S_READ_DATA;
                        default:      state_next = S_DONE;
                    endcase
                end
            end
            S_ID_SWEEP:
            begin
                if (cnt_last_all)
                begin
                    state_next = id_cmd_reg ? S_DONE : S_IDLE;
                end
            end
            S_MUL_RD:     state_next = S_MUL_MUL;
            S_MUL_MUL:    state_next = S_MUL_ACC;
            S_MUL_ACC:    state_next = k_last ? S_MUL_WR : S_MUL_RD;
            S_MUL_WR:     state_next = (i_last && j_last) ? S_COPY_RD : S_MUL_RD;
            S_COPY_RD:    state_next = S_COPY_WR;
            S_COPY_WR:    state_next = cnt_last_nn ? S_DONE : S_COPY_RD;
            S_TR_RD:      state_next = S_TR_WR;
            S_TR_WR:      state_next = (i_last && j_last) ? S_COPY_RD : S_TR_RD;
            S_NM_LAST_RD: state_next = S_NM_LAST;
            S_NM_LAST:
            begin
                if (cur_rdata == 32'd0 || cur_rdata == FX_ONE)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_NM_RD;
                end
            end
            S_NM_RD:      state_next = S_NM_START;
            S_NM_START:   state_next = S_NM_WAIT;
            S_NM_WAIT:
            begin
                if (!alu_stat.div_busy)
                begin
                    state_next = cnt_last_nn ? S_DONE : S_NM_RD;
                end
            end
            S_READ_DATA:  state_next = S_DONE;
            S_DONE:       state_next = res_load ? S_IDLE : S_DONE;
            default:      state_next = S_IDLE;
        endcase
    end

    // memory and unit controls
    always_comb
    begin
        cur_we     = 1'b0;
        cur_waddr  = cnt_reg;
        cur_wdata  = 32'd0;
        cur_raddr  = cnt_reg;
        rhs_we     = 1'b0;
        rhs_raddr  = addr_kj;
        prod_we    = 1'b0;
        prod_waddr = addr_ij;
        prod_wdata = mac_q;
        prod_raddr = cnt_reg;
        alu_ctrl   = '0;
        case (state_reg)
            S_IDLE:
            begin
                cur_raddr = AW'(element_index);
                cur_waddr = AW'(element_index);
                cur_wdata = element_value;
                if (accept && idx_in_range && op == OP_WRITE)
                begin
                    cur_we = 1'b1;
                end
                if (accept && idx_in_range && op == OP_RHS)
                begin
                    rhs_we = 1'b1;
                end
                if (accept && rhs_last && op == OP_RHS)
                begin
                    alu_ctrl.acc_clear = 1'b1;
                end
            end
            S_ID_SWEEP:
            begin
                cur_we    = 1'b1;
                cur_wdata = id_one ? FX_ONE : 32'd0;
            end
            S_MUL_RD:
            begin
                cur_raddr = addr_ik;
            end
            S_MUL_MUL:
            begin
                alu_ctrl.mul_en = 1'b1;
            end
            S_MUL_ACC:
            begin
                alu_ctrl.acc_en = 1'b1;
            end
            S_MUL_WR:
            begin
                prod_we            = 1'b1;
                alu_ctrl.acc_clear = 1'b1;
            end
            S_COPY_WR:
            begin
                cur_we    = 1'b1;
                cur_wdata = prod_rdata;
            end
            S_TR_RD:
            begin
                cur_raddr = addr_ij;
            end
            S_TR_WR:
            begin
                prod_we    = 1'b1;
                prod_waddr = addr_ji;
                prod_wdata = cur_rdata;
            end
            S_NM_LAST_RD:
            begin
                cur_raddr = AW'(nn - NNW'(1));
            end
            S_NM_START:
            begin
                alu_ctrl.div_start = 1'b1;
            end
            S_NM_WAIT:
            begin
                cur_we    = !alu_stat.div_busy;
                cur_wdata = div_q;
            end
            default:
            begin
                cur_we = 1'b0;
            end
        endcase
    end

    // sequencer counters and pending result
    always_comb
    begin
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        diag_pos_next   = diag_pos_reg;
        diag_cnt_next   = diag_cnt_reg;
        id_n_next       = id_n_reg;
        id_cmd_next     = id_cmd_reg;
        inside_next     = inside_reg;
        last_next       = last_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_value_next  = 32'd0;
                    res_status_next = ST_OK;
                    inside_next     = idx_in_range;
                    i_next          = '0;
                    j_next          = '0;
                    k_next          = '0;
                    cnt_next        = '0;
                    diag_pos_next   = '0;
                    diag_cnt_next   = '0;
                    id_n_next       = n_eff;
                    id_cmd_next     = 1'b1;
                end
            end
            S_ID_SWEEP:
            begin
                cnt_next = cnt_reg + AW'(1);
                if (id_one)
                begin
                    diag_pos_next = diag_pos_reg + AW'(id_n_reg) + AW'(1);
                    diag_cnt_next = diag_cnt_reg + DW'(1);
                end
            end
            S_MUL_ACC:
            begin
                if (!k_last)
                begin
                    k_next = k_reg + IW'(1);
                end
            end
            S_MUL_WR, S_TR_WR:
            begin
                k_next   = '0;
                cnt_next = '0;
                if (state_reg == S_MUL_WR && mac_sat)
                begin
                    res_status_next = ST_SAT;
                end
                if (j_last)
                begin
                    j_next = '0;
                    i_next = i_reg + IW'(1);
                end
                else
                begin
                    j_next = j_reg + IW'(1);
                end
            end
            S_COPY_WR:
            begin
                cnt_next = cnt_reg + AW'(1);
            end
            S_NM_LAST:
            begin
                last_next = cur_rdata;
                cnt_next  = '0;
                if (cur_rdata == 32'd0)
                begin
                    res_status_next = ST_NORM_FAIL;
                end
            end
            S_NM_WAIT:
            begin
                if (!alu_stat.div_busy)
                begin
                    cnt_next = cnt_reg + AW'(1);
                    if (div_sat)
                    begin
                        res_status_next = ST_SAT;
                    end
                end
            end
            S_READ_DATA:
            begin
                res_value_next = inside_reg ? cur_rdata : 32'd0;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ID_SWEEP;
            dim_reg       <= 3'd4;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            cnt_reg       <= '0;
            diag_pos_reg  <= '0;
            diag_cnt_reg  <= '0;
            id_n_reg      <= DW'(RST_DIM);
            id_cmd_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            cnt_reg      <= cnt_next;
            diag_pos_reg <= diag_pos_next;
            diag_cnt_reg <= diag_cnt_next;
            id_n_reg     <= id_n_next;
            id_cmd_reg   <= id_cmd_next;
            if (cfg_wr_en)
            begin
                dim_reg <= cfg_wr_data;
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        inside_reg     <= inside_next;
        last_reg       <= last_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        if (res_load)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = out_value_reg;
    assign status     = out_status_reg;

    tme_ram #(.WIDTH(32), .DEPTH(CELLS)) u_cur_ram (
        .clk   (clk),
        .we    (cur_we),
        .waddr (cur_waddr),
        .wdata (cur_wdata),
        .raddr (cur_raddr),
        .rdata (cur_rdata)
    );

    tme_ram #(.WIDTH(32), .DEPTH(CELLS)) u_rhs_ram (
        .clk   (clk),
        .we    (rhs_we),
        .waddr (AW'(element_index)),
        .wdata (element_value),
        .raddr (rhs_raddr),
        .rdata (rhs_rdata)
    );

    tme_ram #(.WIDTH(32), .DEPTH(CELLS)) u_prod_ram (
        .clk   (clk),
        .we    (prod_we),
        .waddr (prod_waddr),
        .wdata (prod_wdata),
        .raddr (prod_raddr),
        .rdata (prod_rdata)
    );

    tme_alu #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_alu (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (alu_ctrl),
        .op_a    (state_reg == S_NM_START ? cur_rdata : cur_rdata),
        .op_b    (state_reg == S_NM_START ? last_reg : rhs_rdata),
        .mac_q   (mac_q),
        .mac_sat (mac_sat),
        .div_q   (div_q),
        .div_sat (div_sat),
        .stat    (alu_stat)
    );

endmodule

// ===== design/tme_checker.sv =====
// ----------------------------------------------------------------------------
// tme_checker
// Port-level checks for the transform matrix engine, bound to the top level.
// ----------------------------------------------------------------------------
module tme_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] read_value,
    input logic [1:0]  status
);

    import tme_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(status))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_NORM_FAIL || status == ST_SAT))
        else $error("illegal status code");

    // one transaction in flight at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after accept");

    a_fail_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_NORM_FAIL |-> read_value == 32'd0)
        else $error("failed normalize returned data");

    // identity load runs after reset before any transaction
    a_init_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready)
        else $error("ready during reset identity load");

endmodule

bind transform_matrix_engine tme_checker u_tme_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_value (read_value),
    .status     (status)
);
